// File: rtl/core/vcs_pkg.sv
// ----------------------------------------------------------------------------
// vcs_pkg
// shared types and fixed field widths for the voxel cell store
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vcs_pkg;

	// fixed port field widths
	localparam int FUNC_W    = 2;
	localparam int COORD_W   = 8;
	localparam int MAT_IN_W  = 16;
	localparam int CNT_OUT_W = 13;
	localparam int REV_W     = 64;

	// request function codes
	typedef enum logic [FUNC_W-1:0] {
		FN_WRITE = 2'd0,
		FN_READ  = 2'd1,
		FN_CLEAR = 2'd2,
		FN_FILL  = 2'd3
	} func_t;

	// one result as handed from the sequencer to the output register
	typedef struct packed {
		logic                 in_range;
		logic [MAT_IN_W-1:0]  read_material;
		logic                 is_solid;
		logic [CNT_OUT_W-1:0] solid_cells;
		logic [REV_W-1:0]     revision_count;
	} res_t;

endpackage

// File: rtl/core/voxel_cell_store_top.sv
// ----------------------------------------------------------------------------
// voxel_cell_store_top
// write/read: one request at a time (accept, then memory read-modify-write);
//   result loaded in the finish step once the output register is free
// clear/fill: a sweep, one cell per cycle through the memory port, then a
//   tail and finish step; a clear with no solid cells goes straight to finish
// reset clears control at once, then a pass over all SIDE^3 cells (4096 at
//   SIDE = 16) writes every cell to zero with in_ready low; config is taken
//   at any time
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module voxel_cell_store_top #(
	parameter int SIDE          = 16,
	parameter int MATERIAL_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration channel: empty material code
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic        [vcs_pkg::MAT_IN_W-1:0]   cfg_data,
	// request channel
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic        [vcs_pkg::FUNC_W-1:0]     func,
	input  logic signed [vcs_pkg::COORD_W-1:0]    pos_x,
	input  logic signed [vcs_pkg::COORD_W-1:0]    pos_y,
	input  logic signed [vcs_pkg::COORD_W-1:0]    pos_z,
	input  logic        [vcs_pkg::MAT_IN_W-1:0]   material,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  in_range,
	output logic        [vcs_pkg::MAT_IN_W-1:0]   read_material,
	output logic                                  is_solid,
	output logic        [vcs_pkg::CNT_OUT_W-1:0]  solid_cells,
	output logic        [vcs_pkg::REV_W-1:0]      revision_count
);

	import vcs_pkg::*;

	localparam int VOLUME = SIDE * SIDE * SIDE;
	localparam int ADDR_W = $clog2(VOLUME);

	// empty material register, cut to the stored material width
	logic [MAT_IN_W-1:0]      empty_q;
	logic [MATERIAL_BITS-1:0] air;

	// output register, decouples the sequencer from the consumer
	logic out_valid_q;
	res_t out_q;
	logic out_free;

	// sequencer to memory
	logic                     res_load;
	res_t                     res;
	logic                     mem_we;
	logic [ADDR_W-1:0]        mem_waddr;
	logic [MATERIAL_BITS-1:0] mem_wdata;
	logic [ADDR_W-1:0]        mem_raddr;
	logic [MATERIAL_BITS-1:0] mem_rdata;

	// config writes are always taken; the user only writes while idle
	assign cfg_ready = 1'b1;
	assign air       = MATERIAL_BITS'(empty_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q <= '0;
		end else if (cfg_valid) begin
			empty_q <= cfg_data;
		end
	end

	// the finishing step waits here until the result slot is free
	assign out_free = !out_valid_q || out_ready;

	vcs_seq #(
		.SIDE   (SIDE),
		.MAT_W  (MATERIAL_BITS),
		.ADDR_W (ADDR_W)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.material  (material),
		.air       (air),
		.out_free  (out_free),
		.res_load  (res_load),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	vcs_cell_mem #(
		.DEPTH  (VOLUME),
		.ADDR_W (ADDR_W),
		.DATA_W (MATERIAL_BITS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign in_range       = out_q.in_range;
	assign read_material  = out_q.read_material;
	assign is_solid       = out_q.is_solid;
	assign solid_cells    = out_q.solid_cells;
	assign revision_count = out_q.revision_count;

endmodule

// File: rtl/core/vcs_cell_mem.sv
// ----------------------------------------------------------------------------
// vcs_cell_mem
// cell storage, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vcs_cell_mem #(
	parameter int DEPTH  = 4096,
	parameter int ADDR_W = 12,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// read returns the old contents when the same address is written
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/vcs_pos_decode.sv
// ----------------------------------------------------------------------------
// vcs_pos_decode
// range check of three signed coordinates and linear cell index
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vcs_pos_decode #(
	parameter int SIDE   = 16,
	parameter int ADDR_W = 12
) (
	input  logic signed [vcs_pkg::COORD_W-1:0] pos_x,
	input  logic signed [vcs_pkg::COORD_W-1:0] pos_y,
	input  logic signed [vcs_pkg::COORD_W-1:0] pos_z,
	output logic                               ok,
	output logic        [ADDR_W-1:0]           idx
);

	import vcs_pkg::*;

	localparam int PLANE = SIDE * SIDE;

	logic ok_x, ok_y, ok_z;

	// non-negative and below the side length
	assign ok_x = ~pos_x[COORD_W-1] && (pos_x[COORD_W-2:0] < (COORD_W-1)'(SIDE));
	assign ok_y = ~pos_y[COORD_W-1] && (pos_y[COORD_W-2:0] < (COORD_W-1)'(SIDE));
	assign ok_z = ~pos_z[COORD_W-1] && (pos_z[COORD_W-2:0] < (COORD_W-1)'(SIDE));
	assign ok   = ok_x && ok_y && ok_z;

	// x + side * y + side^2 * z, constant multipliers only
	assign idx = ADDR_W'(pos_x[COORD_W-2:0])
		+ ADDR_W'(SIDE) * ADDR_W'(pos_y[COORD_W-2:0])
		+ ADDR_W'(PLANE) * ADDR_W'(pos_z[COORD_W-2:0]);

endmodule

// File: rtl/core/vcs_seq.sv
// ----------------------------------------------------------------------------
// vcs_seq
// request sequencer: memory sweep pointer, shared cell compare, count and
// revision registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module vcs_seq #(
	parameter int SIDE   = 16,
	parameter int MAT_W  = 16,
	parameter int ADDR_W = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic        [vcs_pkg::FUNC_W-1:0]   func,
	input  logic signed [vcs_pkg::COORD_W-1:0]  pos_x,
	input  logic signed [vcs_pkg::COORD_W-1:0]  pos_y,
	input  logic signed [vcs_pkg::COORD_W-1:0]  pos_z,
	input  logic        [vcs_pkg::MAT_IN_W-1:0] material,
	input  logic        [MAT_W-1:0]             air,
	input  logic                                out_free,
	output logic                                res_load,
	output vcs_pkg::res_t                       res,
	output logic                                mem_we,
	output logic        [ADDR_W-1:0]            mem_waddr,
	output logic        [MAT_W-1:0]             mem_wdata,
	output logic        [ADDR_W-1:0]            mem_raddr,
	input  logic        [MAT_W-1:0]             mem_rdata
);

	import vcs_pkg::*;

	localparam int VOLUME = SIDE * SIDE * SIDE;
	localparam int CNT_W  = $clog2(VOLUME + 1);
	localparam logic [ADDR_W-1:0] LAST = ADDR_W'(VOLUME - 1);
	localparam logic [CNT_W-1:0]  FULL = CNT_W'(VOLUME);

	typedef enum logic [4:0] {
		ST_INIT  = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_SWEEP = 5'b00100,
		ST_TAIL  = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;

	state_t             st_q;
	func_t              func_q;
	logic               ok_q;
	logic [ADDR_W-1:0]  idx_q;
	logic [MAT_W-1:0]   mat_q;
	logic [ADDR_W-1:0]  ptr_q;
	logic               differ_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [REV_W-1:0]   rev_q;

	logic               ok_d;
	logic [ADDR_W-1:0]  idx_d;
	logic               differ;
	logic               cur_air;
	logic               new_air;
	logic               is_wr;
	logic               is_rd;
	logic               is_sweep;
	logic               cell_wr;
	logic [MAT_W-1:0]   sweep_val;
	logic [CNT_W-1:0]   cnt_d;
	logic [REV_W-1:0]   rev_d;

	vcs_pos_decode #(
		.SIDE   (SIDE),
		.ADDR_W (ADDR_W)
	) u_dec (
		.pos_x (pos_x),
		.pos_y (pos_y),
		.pos_z (pos_z),
		.ok    (ok_d),
		.idx   (idx_d)
	);

	// shared compares against the request material and the empty code
	assign differ  = (mem_rdata != mat_q);
	assign cur_air = (mem_rdata == air);
	assign new_air = (mat_q == air);

	assign is_wr    = (func_q == FN_WRITE);
	assign is_rd    = (func_q == FN_READ);
	assign is_sweep = (func_q == FN_CLEAR) || (func_q == FN_FILL);

	assign sweep_val = (func_q == FN_CLEAR) ? air : mat_q;
	assign in_ready  = (st_q == ST_IDLE);
	assign res_load  = (st_q == ST_FIN) && out_free;
	assign cell_wr   = res_load && is_wr && ok_q && differ;

	// memory port steering
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = mat_q;
		mem_raddr = idx_q;
		case (st_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q;
				mem_wdata = '0;
				mem_raddr = ptr_q;
			end
			ST_IDLE: begin
				mem_raddr = idx_d;
			end
			ST_SWEEP: begin
				mem_we    = 1'b1;
				mem_waddr = ptr_q;
				mem_wdata = sweep_val;
				mem_raddr = ptr_q;
			end
			ST_FIN: begin
				mem_we = cell_wr;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// count and revision after the request
	always_comb begin
		cnt_d = cnt_q;
		rev_d = rev_q;
		if (is_wr && ok_q && differ) begin
			rev_d = rev_q + 1'b1;
			if (cur_air && !new_air && (cnt_q < FULL)) begin
				cnt_d = cnt_q + 1'b1;
			end else if (!cur_air && new_air && (cnt_q != '0)) begin
				cnt_d = cnt_q - 1'b1;
			end
		end else if (is_sweep && differ_q) begin
			rev_d = rev_q + 1'b1;
			cnt_d = ((func_q == FN_CLEAR) || new_air) ? '0 : FULL;
		end
	end

	always_comb begin
		res.in_range       = (is_wr || is_rd) && ok_q;
		res.read_material  = '0;
		res.is_solid       = 1'b0;
		res.solid_cells    = CNT_OUT_W'(cnt_d);
		res.revision_count = rev_d;
		if (is_rd) begin
			res.read_material = ok_q ? MAT_IN_W'(mem_rdata) : MAT_IN_W'(air);
			res.is_solid      = ok_q && !cur_air;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_INIT;
			ptr_q    <= '0;
			differ_q <= 1'b0;
			cnt_q    <= '0;
			rev_q    <= '0;
		end else begin
			case (st_q)
				ST_INIT: begin
					if (ptr_q == LAST) begin
						ptr_q <= '0;
						st_q  <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						ptr_q <= '0;
						case (func_t'(func))
							FN_CLEAR: begin
								differ_q <= (cnt_q != '0);
								st_q     <= (cnt_q != '0) ? ST_SWEEP : ST_FIN;
							end
							FN_FILL: begin
								differ_q <= 1'b0;
								st_q     <= ST_SWEEP;
							end
							default: begin
								differ_q <= 1'b0;
								st_q     <= ST_FIN;
							end
						endcase
					end
				end
				ST_SWEEP: begin
					// read data belongs to the previous address
					if ((func_q == FN_FILL) && (ptr_q != '0) && differ) begin
						differ_q <= 1'b1;
					end
					if (ptr_q == LAST) begin
						ptr_q <= '0;
						st_q  <= ST_TAIL;
					end else begin
						ptr_q <= ptr_q + 1'b1;
					end
				end
				ST_TAIL: begin
					if ((func_q == FN_FILL) && differ) begin
						differ_q <= 1'b1;
					end
					st_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						cnt_q <= cnt_d;
						rev_q <= rev_d;
						st_q  <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_INIT;
				end
			endcase
		end
	end

	// request payload, captured on accept
	always_ff @(posedge clk) begin
		if ((st_q == ST_IDLE) && in_valid) begin
			func_q <= func_t'(func);
			ok_q   <= ok_d;
			idx_q  <= idx_d;
			mat_q  <= MAT_W'(material);
		end
	end

`ifndef NO_ASSERTIONS
	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (st_q == ST_INIT || st_q == ST_SWEEP || st_q == ST_FIN))
		else $error("cell write outside init, sweep or finish");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL)
		else $error("solid count above volume");

	a_rev_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!res_load |=> $stable(rev_q))
		else $error("revision moved without a result");

	a_sweep_end: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SWEEP && ptr_q == LAST) |=> (st_q == ST_TAIL && ptr_q == '0))
		else $error("sweep did not end at the last cell");
`endif

endmodule
